>>> sv/dbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared constants, codes and types of the decimal register ALU.
// ----------------------------------------------------------------------------
package dbr_pkg;

  localparam int NUM_REGS   = 26;
  localparam int MAX_DIGITS = 512;
  localparam int LIT_SEL    = 26;
  localparam int DEC_BASE   = 10;
  localparam int EXP_CAP    = 1000000;

  localparam int REG_W      = 5;
  localparam int TYPE_W     = 3;
  localparam int DIG_W      = 4;
  localparam int RIDX_IN_W  = 10;
  localparam int STAT_W     = 2;
  localparam int OLEN_W     = 10;

  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int RIDX_W = $clog2(2 * MAX_DIGITS);
  localparam int LR_W   = $clog2(2 * MAX_DIGITS + 1);
  localparam int EXP_W  = $clog2(EXP_CAP + 1);
  localparam int DS_DEPTH = NUM_REGS * MAX_DIGITS;
  localparam int DS_AW    = $clog2(DS_DEPTH);

  localparam logic [TYPE_W-1:0] REQ_LOAD   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ASSIGN = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_MUL    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_POW    = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_BIG = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_READ_RD, S_READ_WT, S_SETUP,
    S_SRC_RD, S_SRC_WR, S_DST_RD, S_DST_WR, S_DISPATCH,
    S_ADD_RD, S_ADD_WR, S_ADD_CY,
    S_MUL_ARD, S_MUL_ALD, S_MUL_RD, S_MUL_WR, S_MUL_CY, S_MUL_END,
    S_CHECK, S_EXP_RD, S_EXP_ACC, S_POW_DEC, S_BASE_RD, S_BASE_WR,
    S_CUR_RD, S_CUR_WR, S_WB_RD, S_WB_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {WB_R, WB_C, WB_ONE} wb_src_t;

  typedef struct packed {
    logic             mul;
    logic [DIG_W-1:0] x;
    logic [DIG_W-1:0] y;
    logic [DIG_W-1:0] acc;
    logic [DIG_W-1:0] carry;
  } du_req_t;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic [DIG_W-1:0] carry;
  } du_rsp_t;

endpackage

>>> sv/dbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbr_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dbr_digit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbr_digit_unit
// Shared decimal digit step: sum or product plus accumulator and carry,
// split into a digit and a carry.
// ----------------------------------------------------------------------------
module dbr_digit_unit import dbr_pkg::*; (
  input  du_req_t req,
  output du_rsp_t rsp
);

  logic [6:0]  term;
  logic [6:0]  sum;
  logic [14:0] scaled;
  logic [3:0]  quot;
  logic [6:0]  rem;

  always_comb begin
    term   = req.mul ? 7'(req.x * req.y) : 7'(req.x + req.y);
    sum    = term + 7'(req.acc) + 7'(req.carry);
    scaled = 15'(sum) * 15'd205;
    quot   = scaled[14:11];
    rem    = sum - 7'(quot) * 7'(DEC_BASE);
    rsp.digit = rem[3:0];
    rsp.carry = quot;
  end

endmodule

>>> sv/decimal_bignum_register_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bignum_register_alu
// Decimal register file with a digit-serial add / multiply / power sequencer.
// Assign and add copy both operands into scratch RAMs and write the result
// back; multiply adds a digit-product loop; power adds one multiply plus a
// copy per exponent step. The arithmetic shares the single digit unit and the
// one-read-port scratch RAMs. One transaction at a time; busy holds start off.
// Results strobe for one cycle and cannot be stalled. Reset clears lengths to
// one and per-register valid bits; no clearing pass over the digit store.
// ----------------------------------------------------------------------------
module decimal_bignum_register_alu import dbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [TYPE_W-1:0]    in_req_type,
  input  logic [REG_W-1:0]     in_dest_reg,
  input  logic [REG_W-1:0]     in_src_reg,
  input  logic [DIG_W-1:0]     in_literal_digit,
  input  logic                 in_literal_first,
  input  logic [RIDX_IN_W-1:0] in_read_index,
  output logic                 out_strobe,
  output logic [STAT_W-1:0]    out_status,
  output logic [DIG_W-1:0]     out_digit_out,
  output logic [OLEN_W-1:0]    out_length_out
);

  function automatic logic [DS_AW-1:0] ds_addr(input logic [REG_W-1:0] r,
                                               input logic [IDX_W-1:0] k);
    return DS_AW'(r) * DS_AW'(MAX_DIGITS) + DS_AW'(k);
  endfunction

  state_t state_r, state_nxt;

  logic [TYPE_W-1:0]    type_r;
  logic [REG_W-1:0]     dest_r, src_r;
  logic [DIG_W-1:0]     dig_r;
  logic                 first_r;
  logic [RIDX_IN_W-1:0] ridx_r;

  logic [LEN_W-1:0]  la_r, la_nxt, lb_r, lb_nxt, lc_r, lc_nxt;
  logic [LR_W-1:0]   lr_r, lr_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [DIG_W-1:0]  carry_r, carry_nxt, adig_r, adig_nxt;
  logic              c_zero_r, c_zero_nxt, c_one_r, c_one_nxt, b_zero_r, b_zero_nxt;
  logic [EXP_W-1:0]  e_r, e_nxt, k_r, k_nxt;
  wb_src_t           wb_r, wb_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DIG_W-1:0]  dout_r, dout_nxt;
  logic [LEN_W-1:0]  lout_r, lout_nxt;
  logic [LEN_W-1:0]  lit_len_r, lit_len_nxt;
  logic              lit_over_r, lit_over_nxt, lit_zero_r, lit_zero_nxt;
  logic              rl_we;

  logic [LEN_W-1:0]    reg_len_r [NUM_REGS];
  logic [NUM_REGS-1:0] reg_vld_r;

  logic                ds_we;
  logic [DS_AW-1:0]    ds_waddr, ds_raddr;
  logic [DIG_W-1:0]    ds_wdata, ds_rdata;
  logic                lit_we;
  logic [IDX_W-1:0]    lit_waddr, lit_raddr;
  logic [DIG_W-1:0]    lit_wdata, lit_rdata;
  logic                b_we, c_we, r_we;
  logic [IDX_W-1:0]    b_waddr, b_raddr, c_waddr, c_raddr;
  logic [RIDX_W-1:0]   r_waddr, r_raddr;
  logic [DIG_W-1:0]    b_wdata, b_rdata, c_wdata, c_rdata, r_wdata, r_rdata;

  du_req_t du_req;
  du_rsp_t du_rsp;

  logic             accept;
  logic             dest_ok_in, src_is_lit, src_ok, dst_vld, src_vld;
  logic [REG_W-1:0] len_idx;
  logic [LEN_W-1:0] len_rd, n_add, lit_ridx, len_eff;
  logic [RIDX_W-1:0] rij;
  logic [EXP_W+3:0] e_ext;
  logic             over_eff;
  logic [DIG_W-1:0] dsat, sd, dd;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign dest_ok_in = int'(in_dest_reg) < NUM_REGS;
  assign src_is_lit = int'(src_r) == LIT_SEL;
  assign src_ok     = int'(src_r) < NUM_REGS;
  assign dst_vld    = reg_vld_r[dest_r];
  assign src_vld    = src_ok && reg_vld_r[src_r];
  assign len_idx    = (state_r == S_IDLE) ? in_dest_reg : src_r;
  assign len_rd     = (int'(len_idx) < NUM_REGS) ? reg_len_r[len_idx] : LEN_W'(1);
  assign n_add      = (la_r > lb_r) ? la_r : lb_r;
  assign lit_ridx   = lit_len_r - LEN_W'(1) - i_r;
  assign rij        = RIDX_W'(i_r) + RIDX_W'(j_r);
  assign e_ext      = (EXP_W+4)'(e_r) * (EXP_W+4)'(DEC_BASE) + (EXP_W+4)'(b_rdata);
  assign len_eff    = first_r ? '0 : lit_len_r;
  assign over_eff   = first_r ? 1'b0 : lit_over_r;
  assign dsat       = (dig_r > DIG_W'(9)) ? DIG_W'(9) : dig_r;
  assign sd         = src_is_lit ? ((lit_len_r == '0) ? '0 : lit_rdata)
                                 : (src_vld ? ds_rdata : '0);
  assign dd         = dst_vld ? ds_rdata : '0;

  dbr_ram #(.W(DIG_W), .DEPTH(DS_DEPTH)) u_ds (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );
  dbr_ram #(.W(DIG_W), .DEPTH(MAX_DIGITS)) u_lit (
    .clk(clk), .we(lit_we), .waddr(lit_waddr), .wdata(lit_wdata),
    .raddr(lit_raddr), .rdata(lit_rdata)
  );
  dbr_ram #(.W(DIG_W), .DEPTH(MAX_DIGITS)) u_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  dbr_ram #(.W(DIG_W), .DEPTH(MAX_DIGITS)) u_c (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );
  dbr_ram #(.W(DIG_W), .DEPTH(2 * MAX_DIGITS)) u_r (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  dbr_digit_unit u_du (.req(du_req), .rsp(du_rsp));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_LOAD) state_nxt = S_LOAD;
          else if (!dest_ok_in) state_nxt = S_DONE;
          else if (in_req_type == REQ_READ) state_nxt = S_READ_RD;
          else if (in_req_type == REQ_ASSIGN || in_req_type == REQ_ADD ||
                   in_req_type == REQ_MUL || in_req_type == REQ_POW) state_nxt = S_SETUP;
          else state_nxt = S_DONE;
        end
      end
      S_LOAD:    state_nxt = S_DONE;
      S_READ_RD: state_nxt = S_READ_WT;
      S_READ_WT: state_nxt = S_DONE;
      S_SETUP: begin
        priority if (src_is_lit) state_nxt = lit_over_r ? S_DONE : S_SRC_RD;
        else if (!src_ok) state_nxt = S_DONE;
        else state_nxt = S_SRC_RD;
      end
      S_SRC_RD:  state_nxt = S_SRC_WR;
      S_SRC_WR:  state_nxt = (i_r == lb_r - LEN_W'(1)) ? S_DST_RD : S_SRC_RD;
      S_DST_RD:  state_nxt = S_DST_WR;
      S_DST_WR:  state_nxt = (i_r == la_r - LEN_W'(1)) ? S_DISPATCH : S_DST_RD;
      S_DISPATCH: begin
        priority if (type_r == REQ_ASSIGN) state_nxt = S_WB_RD;
        else if (type_r == REQ_ADD) state_nxt = S_ADD_RD;
        else if (type_r == REQ_MUL) state_nxt = S_MUL_ARD;
        else state_nxt = S_EXP_RD;
      end
      S_ADD_RD:  state_nxt = S_ADD_WR;
      S_ADD_WR:  state_nxt = (i_r == n_add - LEN_W'(1)) ? S_ADD_CY : S_ADD_RD;
      S_ADD_CY:  state_nxt = S_CHECK;
      S_MUL_ARD: state_nxt = S_MUL_ALD;
      S_MUL_ALD: state_nxt = S_MUL_RD;
      S_MUL_RD:  state_nxt = S_MUL_WR;
      S_MUL_WR:  state_nxt = (j_r == lb_r - LEN_W'(1)) ? S_MUL_CY : S_MUL_RD;
      S_MUL_CY:  state_nxt = (i_r == lc_r - LEN_W'(1)) ? S_MUL_END : S_MUL_ARD;
      S_MUL_END: state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (lr_r > LR_W'(MAX_DIGITS)) state_nxt = S_DONE;
        else if (type_r == REQ_POW) state_nxt = S_CUR_RD;
        else state_nxt = S_WB_RD;
      end
      S_EXP_RD:  state_nxt = S_EXP_ACC;
      S_EXP_ACC: state_nxt = (i_r == '0) ? S_POW_DEC : S_EXP_RD;
      S_POW_DEC: begin
        if (e_r == '0 || e_r == EXP_W'(1) || c_zero_r || c_one_r) state_nxt = S_WB_RD;
        else state_nxt = S_BASE_RD;
      end
      S_BASE_RD: state_nxt = S_BASE_WR;
      S_BASE_WR: state_nxt = (i_r == la_r - LEN_W'(1)) ? S_MUL_ARD : S_BASE_RD;
      S_CUR_RD:  state_nxt = S_CUR_WR;
      S_CUR_WR: begin
        if (i_r == lc_r - LEN_W'(1)) begin
          state_nxt = (k_r + EXP_W'(1) == e_r) ? S_WB_RD : S_MUL_ARD;
        end else begin
          state_nxt = S_CUR_RD;
        end
      end
      S_WB_RD:   state_nxt = S_WB_WR;
      S_WB_WR:   state_nxt = (LR_W'(i_r) == lr_r - LR_W'(1)) ? S_DONE : S_WB_RD;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    la_nxt = la_r;  lb_nxt = lb_r;  lc_nxt = lc_r;  lr_nxt = lr_r;
    i_nxt = i_r;    j_nxt = j_r;    carry_nxt = carry_r;  adig_nxt = adig_r;
    c_zero_nxt = c_zero_r;  c_one_nxt = c_one_r;  b_zero_nxt = b_zero_r;
    e_nxt = e_r;    k_nxt = k_r;    wb_nxt = wb_r;
    status_nxt = status_r;  dout_nxt = dout_r;  lout_nxt = lout_r;
    lit_len_nxt = lit_len_r;  lit_over_nxt = lit_over_r;  lit_zero_nxt = lit_zero_r;
    rl_we = 1'b0;
    ds_we = 1'b0;  ds_waddr = '0;  ds_wdata = '0;  ds_raddr = '0;
    lit_we = 1'b0; lit_waddr = '0; lit_wdata = dsat; lit_raddr = lit_ridx[IDX_W-1:0];
    b_we = 1'b0;   b_waddr = i_r[IDX_W-1:0];  b_wdata = '0;  b_raddr = '0;
    c_we = 1'b0;   c_waddr = i_r[IDX_W-1:0];  c_wdata = '0;  c_raddr = '0;
    r_we = 1'b0;   r_waddr = RIDX_W'(i_r);    r_wdata = '0;  r_raddr = '0;
    du_req = '{mul: 1'b0, x: '0, y: '0, acc: '0, carry: carry_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          la_nxt     = len_rd;
          status_nxt = ST_OK;
          dout_nxt   = '0;
          lout_nxt   = dest_ok_in ? len_rd : '0;
        end
      end
      S_LOAD: begin
        lit_len_nxt  = len_eff;
        lit_over_nxt = over_eff;
        lout_nxt     = len_eff;
        if (over_eff) begin
          status_nxt = ST_LIT;
        end else if (len_eff == '0 || (len_eff == LEN_W'(1) && lit_zero_r)) begin
          lit_we       = 1'b1;
          lit_waddr    = '0;
          lit_len_nxt  = LEN_W'(1);
          lit_zero_nxt = (dsat == '0);
          lout_nxt     = LEN_W'(1);
        end else if (len_eff >= LEN_W'(MAX_DIGITS)) begin
          lit_over_nxt = 1'b1;
          status_nxt   = ST_LIT;
        end else begin
          lit_we       = 1'b1;
          lit_waddr    = len_eff[IDX_W-1:0];
          lit_len_nxt  = len_eff + LEN_W'(1);
          lit_zero_nxt = 1'b0;
          lout_nxt     = len_eff + LEN_W'(1);
        end
      end
      S_READ_RD: begin
        ds_raddr = ds_addr(dest_r, IDX_W'(ridx_r - RIDX_IN_W'(1)));
      end
      S_READ_WT: begin
        dout_nxt = (ridx_r != '0 && ridx_r <= la_r && dst_vld) ? ds_rdata : '0;
      end
      S_SETUP: begin
        i_nxt = '0;
        if (src_is_lit) begin
          if (lit_over_r) status_nxt = ST_LIT;
          else lb_nxt = (lit_len_r == '0) ? LEN_W'(1) : lit_len_r;
        end else if (src_ok) begin
          lb_nxt = len_rd;
        end
      end
      S_SRC_RD: begin
        ds_raddr = ds_addr(src_r, i_r[IDX_W-1:0]);
      end
      S_SRC_WR: begin
        b_we = 1'b1;  b_wdata = sd;
        r_we = 1'b1;  r_wdata = sd;
        if (i_r == '0) b_zero_nxt = (lb_r == LEN_W'(1)) && (sd == '0);
        i_nxt = (i_r == lb_r - LEN_W'(1)) ? '0 : i_r + LEN_W'(1);
      end
      S_DST_RD: begin
        ds_raddr = ds_addr(dest_r, i_r[IDX_W-1:0]);
      end
      S_DST_WR: begin
        c_we = 1'b1;  c_wdata = dd;
        if (i_r == '0) begin
          c_zero_nxt = (la_r == LEN_W'(1)) && (dd == '0);
          c_one_nxt  = (la_r == LEN_W'(1)) && (dd == DIG_W'(1));
        end
        i_nxt = (i_r == la_r - LEN_W'(1)) ? '0 : i_r + LEN_W'(1);
      end
      S_DISPATCH: begin
        carry_nxt = '0;
        lr_nxt    = LR_W'(lb_r);
        wb_nxt    = WB_R;
        lc_nxt    = la_r;
        e_nxt     = '0;
        i_nxt     = (type_r == REQ_POW) ? lb_r - LEN_W'(1) : '0;
      end
      S_ADD_RD: begin
        c_raddr = i_r[IDX_W-1:0];
        b_raddr = i_r[IDX_W-1:0];
      end
      S_ADD_WR: begin
        du_req.x  = (i_r < la_r) ? c_rdata : '0;
        du_req.y  = (i_r < lb_r) ? b_rdata : '0;
        r_we      = 1'b1;
        r_wdata   = du_rsp.digit;
        carry_nxt = du_rsp.carry;
        i_nxt     = i_r + LEN_W'(1);
      end
      S_ADD_CY: begin
        if (carry_r != '0) begin
          r_we    = 1'b1;
          r_waddr = RIDX_W'(n_add);
          r_wdata = carry_r;
          lr_nxt  = LR_W'(n_add) + LR_W'(1);
        end else begin
          lr_nxt  = LR_W'(n_add);
        end
      end
      S_MUL_ARD: begin
        c_raddr = i_r[IDX_W-1:0];
      end
      S_MUL_ALD: begin
        adig_nxt  = c_rdata;
        j_nxt     = '0;
        carry_nxt = '0;
      end
      S_MUL_RD: begin
        b_raddr = j_r[IDX_W-1:0];
        r_raddr = rij;
      end
      S_MUL_WR: begin
        du_req.mul = 1'b1;
        du_req.x   = adig_r;
        du_req.y   = b_rdata;
        du_req.acc = (i_r == '0) ? '0 : r_rdata;
        r_we       = 1'b1;
        r_waddr    = rij;
        r_wdata    = du_rsp.digit;
        carry_nxt  = du_rsp.carry;
        j_nxt      = j_r + LEN_W'(1);
      end
      S_MUL_CY: begin
        r_we    = 1'b1;
        r_waddr = RIDX_W'(i_r) + RIDX_W'(lb_r);
        r_wdata = carry_r;
        i_nxt   = (i_r == lc_r - LEN_W'(1)) ? '0 : i_r + LEN_W'(1);
      end
      S_MUL_END: begin
        priority if (c_zero_r || b_zero_r) lr_nxt = LR_W'(1);
        else if (carry_r != '0) lr_nxt = LR_W'(lc_r) + LR_W'(lb_r);
        else lr_nxt = LR_W'(lc_r) + LR_W'(lb_r) - LR_W'(1);
      end
      S_CHECK: begin
        i_nxt = '0;
        priority if (lr_r > LR_W'(MAX_DIGITS)) status_nxt = ST_BIG;
        else if (type_r == REQ_POW) lc_nxt = lr_r[LEN_W-1:0];
        else wb_nxt = WB_R;
      end
      S_EXP_RD: begin
        b_raddr = i_r[IDX_W-1:0];
      end
      S_EXP_ACC: begin
        e_nxt = (e_ext > (EXP_W+4)'(EXP_CAP)) ? EXP_W'(EXP_CAP) : e_ext[EXP_W-1:0];
        i_nxt = (i_r == '0) ? '0 : i_r - LEN_W'(1);
      end
      S_POW_DEC: begin
        i_nxt = '0;
        priority if (e_r == '0) begin
          lr_nxt = LR_W'(1);
          wb_nxt = WB_ONE;
        end else if (e_r == EXP_W'(1) || c_zero_r || c_one_r) begin
          lr_nxt = LR_W'(la_r);
          wb_nxt = WB_C;
        end else begin
          lb_nxt     = la_r;
          b_zero_nxt = 1'b0;
          k_nxt      = EXP_W'(1);
          lc_nxt     = la_r;
        end
      end
      S_BASE_RD: begin
        c_raddr = i_r[IDX_W-1:0];
      end
      S_BASE_WR: begin
        b_we    = 1'b1;
        b_wdata = c_rdata;
        i_nxt   = (i_r == la_r - LEN_W'(1)) ? '0 : i_r + LEN_W'(1);
      end
      S_CUR_RD: begin
        r_raddr = RIDX_W'(i_r);
      end
      S_CUR_WR: begin
        c_we    = 1'b1;
        c_wdata = r_rdata;
        if (i_r == lc_r - LEN_W'(1)) begin
          i_nxt  = '0;
          k_nxt  = k_r + EXP_W'(1);
          lr_nxt = LR_W'(lc_r);
          wb_nxt = WB_C;
        end else begin
          i_nxt  = i_r + LEN_W'(1);
        end
      end
      S_WB_RD: begin
        r_raddr = RIDX_W'(i_r);
        c_raddr = i_r[IDX_W-1:0];
      end
      S_WB_WR: begin
        ds_we    = 1'b1;
        ds_waddr = ds_addr(dest_r, i_r[IDX_W-1:0]);
        unique case (wb_r)
          WB_ONE:  ds_wdata = (i_r == '0) ? DIG_W'(1) : '0;
          WB_C:    ds_wdata = c_rdata;
          default: ds_wdata = r_rdata;
        endcase
        i_nxt = i_r + LEN_W'(1);
        if (LR_W'(i_r) == lr_r - LR_W'(1)) begin
          rl_we      = 1'b1;
          status_nxt = ST_OK;
          lout_nxt   = lr_r[LEN_W-1:0];
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lit_len_r  <= '0;
      lit_over_r <= 1'b0;
      lit_zero_r <= 1'b0;
      reg_vld_r  <= '0;
      for (int r = 0; r < NUM_REGS; r++) begin
        reg_len_r[r] <= LEN_W'(1);
      end
    end else begin
      state_r    <= state_nxt;
      lit_len_r  <= lit_len_nxt;
      lit_over_r <= lit_over_nxt;
      lit_zero_r <= lit_zero_nxt;
      if (rl_we) begin
        reg_len_r[dest_r] <= lr_r[LEN_W-1:0];
        reg_vld_r[dest_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r  <= in_req_type;
      dest_r  <= in_dest_reg;
      src_r   <= in_src_reg;
      dig_r   <= in_literal_digit;
      first_r <= in_literal_first;
      ridx_r  <= in_read_index;
    end
    la_r <= la_nxt;  lb_r <= lb_nxt;  lc_r <= lc_nxt;  lr_r <= lr_nxt;
    i_r <= i_nxt;    j_r <= j_nxt;    carry_r <= carry_nxt;  adig_r <= adig_nxt;
    c_zero_r <= c_zero_nxt;  c_one_r <= c_one_nxt;  b_zero_r <= b_zero_nxt;
    e_r <= e_nxt;    k_r <= k_nxt;    wb_r <= wb_nxt;
    status_r <= status_nxt;  dout_r <= dout_nxt;  lout_r <= lout_nxt;
  end

  assign out_strobe     = (state_r == S_DONE);
  assign out_status     = status_r;
  assign out_digit_out  = dout_r;
  assign out_length_out = OLEN_W'(lout_r);

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result strobe outside a transaction");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted transaction did not raise busy");
  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    lit_len_r <= LEN_W'(MAX_DIGITS)) else $error("literal length overran");
  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_digit_out <= DIG_W'(9) && out_status != 2'd3))
    else $error("bad result fields");

endmodule
